/* src/vncps_pkg.sv */
// Package for the voxel nearest-center point selector.
// Holds transaction payload types, action and register codes, and the control FSM type.
// No dependencies; used by vncps_div, the top level and the testbench.
package vncps_pkg;

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BASE_X      = 3'd0;
  localparam logic [2:0] CFG_BASE_Y      = 3'd1;
  localparam logic [2:0] CFG_BASE_Z      = 3'd2;
  localparam logic [2:0] CFG_CELL_LENGTH = 3'd3;
  localparam logic [2:0] CFG_CELLS_X     = 3'd4;
  localparam logic [2:0] CFG_CELLS_Y     = 3'd5;
  localparam logic [2:0] CFG_CELLS_Z     = 3'd6;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]        point_payload;
    logic [11:0]        read_cell;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic               cell_occupied;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_payload;
    logic [11:0]        out_cell;
  } out_item_t;

  // Control of one divider lane.
  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DIV,
    S_CELL1,
    S_CELL2,
    S_CELL3,
    S_SQ,
    S_SUM,
    S_CMP,
    S_SPILL
  } state_t;

endpackage

/* src/vncps_div.sv */
// Restoring divider lane: 32-bit unsigned dividend by 31-bit divisor, one bit per step.
// Depends on vncps_pkg for the control struct.
module vncps_div (
  input  logic                clk,
  input  vncps_pkg::div_ctrl_t ctrl,
  input  logic [31:0]         dividend,
  input  logic [30:0]         divisor,
  output logic [31:0]         quotient
);

  logic [30:0] rem;
  logic [31:0] quo;
  logic [31:0] trial;
  logic        ge;

  // Trial subtraction of one quotient bit.
  assign trial = {rem, quo[31]};
  assign ge    = trial >= {1'b0, divisor};

  // Load on start, then shift one dividend bit in per step.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= dividend;
    end else if (ctrl.step) begin
      rem <= ge ? 31'(trial - {1'b0, divisor}) : trial[30:0];
      quo <= {quo[30:0], ge};
    end
  end

  assign quotient = quo;

endmodule

/* src/voxel_nearest_center_point_selector_unit.sv */
// Voxel grid selector that keeps, per cell, the point nearest the cell center.
// Depends on vncps_pkg and vncps_div.
//
// After reset the block sweeps every entry of its cell memory and accepts no transaction
// meanwhile; a clear action runs the same sweep. An insert keeps the block busy after it
// is accepted: the three bit-serial dividers produce one quotient bit per cycle each, and
// then come the index, distance and read-modify-write stages on the single cell memory. A
// read fetches its cell memory entry as it is accepted and loads it into the output register
// from the read state. One transaction is worked at a time; a finished result waits in the
// output register while the next transaction is accepted, and a read or a spill that finds
// the output register still full holds there until it drains.
module voxel_nearest_center_point_selector_unit #(
  parameter int MAX_CELLS    = 4096,
  parameter int COORD_BITS   = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vncps_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vncps_pkg::out_item_t out_item
);

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CB = COORD_BITS;
  localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int MW = 1 + 64 + 3 * CB + PW;
  localparam int OCC_B = MW - 1;
  localparam int DIST_B = MW - 2;
  localparam int X_B = 3 * CB + PW - 1;
  localparam int Y_B = 2 * CB + PW - 1;
  localparam int Z_B = CB + PW - 1;

  // Configuration registers.
  logic signed [31:0] base_x, base_y, base_z;
  logic [30:0]        cell_length;
  logic [12:0]        cells_x, cells_y, cells_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x      <= '0;
      base_y      <= '0;
      base_z      <= '0;
      cell_length <= 31'd65536;
      cells_x     <= 13'd16;
      cells_y     <= 13'd16;
      cells_z     <= 13'd16;
    end else if (cfg_write) begin
      case (cfg_index)
        vncps_pkg::CFG_BASE_X:      base_x      <= cfg_data;
        vncps_pkg::CFG_BASE_Y:      base_y      <= cfg_data;
        vncps_pkg::CFG_BASE_Z:      base_z      <= cfg_data;
        vncps_pkg::CFG_CELL_LENGTH: cell_length <= cfg_data[30:0];
        vncps_pkg::CFG_CELLS_X:     cells_x     <= cfg_data[12:0];
        vncps_pkg::CFG_CELLS_Y:     cells_y     <= cfg_data[12:0];
        vncps_pkg::CFG_CELLS_Z:     cells_z     <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Zero length and zero counts behave as one.
  logic [30:0] len;
  logic [12:0] cnt_x, cnt_y, cnt_z;
  assign len   = (cell_length == '0) ? 31'd1 : cell_length;
  assign cnt_x = (cells_x == '0) ? 13'd1 : cells_x;
  assign cnt_y = (cells_y == '0) ? 13'd1 : cells_y;
  assign cnt_z = (cells_z == '0) ? 13'd1 : cells_z;

  function automatic logic [12:0] clamp_idx(logic neg, logic [31:0] q, logic [12:0] cnt);
    if (neg) return 13'd0;
    if (q >= {19'd0, cnt}) return 13'(cnt - 13'd1);
    return q[12:0];
  endfunction

  // Doubled offset from the cell center; returns {saturate, magnitude}.
  function automatic logic [32:0] center_err(logic signed [32:0] d, logic [43:0] pl,
                                             logic [30:0] l);
    logic signed [45:0] e;
    logic [45:0]        a;
    e = ((46'(d) - $signed({2'b00, pl})) <<< 1) - $signed({15'd0, l});
    a = e[45] ? 46'(-e) : 46'(e);
    return {|a[45:32], a[31:0]};
  endfunction

  vncps_pkg::state_t state, state_next;
  logic [AW-1:0]    clr_cnt;
  logic [4:0]       div_cnt;
  logic             accept;

  // Working registers of the current transaction.
  logic [11:0]        rd_cell;
  logic               rd_ok;
  logic signed [31:0] pt_x, pt_y, pt_z;
  logic [PW-1:0]      pt_pay;
  logic signed [32:0] dx, dy, dz;
  logic [12:0]        idx_x, idx_y, idx_z;
  logic [25:0]        mul_zy;
  logic [43:0]        plen_x, plen_y, plen_z;
  logic [39:0]        cell_full;
  logic [32:0]        err_x, err_y, err_z;
  logic [63:0]        sq_x, sq_y, sq_z;
  logic [63:0]        pt_dist;
  logic [65:0]        dist_sum;

  // Per-axis coordinates of the offered point, sign-extended from COORD_BITS.
  logic signed [31:0] in_x, in_y, in_z;
  assign in_x = 32'(signed'(in_item.point_x[CB-1:0]));
  assign in_y = 32'(signed'(in_item.point_y[CB-1:0]));
  assign in_z = 32'(signed'(in_item.point_z[CB-1:0]));

  // Offsets of the offered point from the grid base, loaded into the dividers as an insert is accepted.
  logic [31:0] off_x, off_y, off_z;
  assign off_x = in_x - base_x;
  assign off_y = in_y - base_y;
  assign off_z = in_z - base_z;

  // Dividers, one per axis.
  vncps_pkg::div_ctrl_t div_ctrl;
  logic [31:0]          q_x, q_y, q_z;

  vncps_div u_div_x (.clk(clk), .ctrl(div_ctrl), .dividend(off_x), .divisor(len),
                     .quotient(q_x));
  vncps_div u_div_y (.clk(clk), .ctrl(div_ctrl), .dividend(off_y), .divisor(len),
                     .quotient(q_y));
  vncps_div u_div_z (.clk(clk), .ctrl(div_ctrl), .dividend(off_z), .divisor(len),
                     .quotient(q_z));

  // Cell memory: occupancy, best distance and kept point per cell.
  logic [MW-1:0] mem [MAX_CELLS];
  logic [MW-1:0] mem_q, mem_wd;
  logic [AW-1:0] mem_wa, mem_ra;
  logic          mem_we, mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  // Fields of the entry just read.
  logic               mq_occ;
  logic [63:0]        mq_dist;
  logic signed [31:0] mq_x, mq_y, mq_z;
  logic [31:0]        mq_pay;
  assign mq_occ  = mem_q[OCC_B];
  assign mq_dist = mem_q[DIST_B -: 64];
  assign mq_x    = 32'(signed'(mem_q[X_B -: CB]));
  assign mq_y    = 32'(signed'(mem_q[Y_B -: CB]));
  assign mq_z    = 32'(signed'(mem_q[Z_B -: CB]));
  assign mq_pay  = 32'(mem_q[PW-1:0]);

  logic in_range;
  assign in_range = cell_full < 40'(MAX_CELLS);
  assign dist_sum = 66'(sq_x) + 66'(sq_y) + 66'(sq_z);
  assign accept   = in_valid && in_ready;

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= vncps_pkg::S_CLEAR;
      clr_cnt <= '0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == vncps_pkg::S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      else clr_cnt <= '0;
      if (state == vncps_pkg::S_DIV) div_cnt <= div_cnt + 5'd1;
      else div_cnt <= '0;
    end
  end

  // Datapath registers, loaded stage by stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_cell <= in_item.read_cell;
      rd_ok   <= {{(33 - 12){1'b0}}, in_item.read_cell} < 33'(MAX_CELLS);
      pt_x    <= in_x;
      pt_y    <= in_y;
      pt_z    <= in_z;
      pt_pay  <= in_item.point_payload[PW-1:0];
      dx      <= 33'(in_x) - 33'(base_x);
      dy      <= 33'(in_y) - 33'(base_y);
      dz      <= 33'(in_z) - 33'(base_z);
    end
    if (state == vncps_pkg::S_CELL1) begin
      idx_x <= clamp_idx(dx[32], q_x, cnt_x);
      idx_y <= clamp_idx(dy[32], q_y, cnt_y);
      idx_z <= clamp_idx(dz[32], q_z, cnt_z);
    end
    if (state == vncps_pkg::S_CELL2) begin
      mul_zy <= idx_z * cnt_y;
      plen_x <= idx_x * len;
      plen_y <= idx_y * len;
      plen_z <= idx_z * len;
    end
    if (state == vncps_pkg::S_CELL3) begin
      cell_full <= (27'(mul_zy) + 27'(idx_y)) * cnt_x + 40'(idx_x);
      err_x     <= center_err(dx, plen_x, len);
      err_y     <= center_err(dy, plen_y, len);
      err_z     <= center_err(dz, plen_z, len);
    end
    if (state == vncps_pkg::S_SQ) begin
      sq_x <= err_x[32] ? '1 : err_x[31:0] * err_x[31:0];
      sq_y <= err_y[32] ? '1 : err_y[31:0] * err_y[31:0];
      sq_z <= err_z[32] ? '1 : err_z[31:0] * err_z[31:0];
    end
    if (state == vncps_pkg::S_SUM) begin
      pt_dist <= (|dist_sum[65:64]) ? '1 : dist_sum[63:0];
    end
  end

  // Output register.
  logic                 out_load, slot_free;
  vncps_pkg::out_item_t out_next;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_item <= out_next;
  end

  // Sequencer: next state, memory access and result selection.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_ctrl   = '0;
    mem_we     = 1'b0;
    mem_wa     = cell_full[AW-1:0];
    mem_wd     = {1'b1, pt_dist, pt_x[CB-1:0], pt_y[CB-1:0], pt_z[CB-1:0], pt_pay};
    mem_re     = 1'b0;
    mem_ra     = cell_full[AW-1:0];
    out_load   = 1'b0;
    out_next   = '{cell_occupied: 1'b1, out_x: pt_x, out_y: pt_y, out_z: pt_z,
                   out_payload: 32'(pt_pay), out_cell: cell_full[11:0]};
    case (state)
      vncps_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        mem_wd = '0;
        if (clr_cnt == AW'(MAX_CELLS - 1)) state_next = vncps_pkg::S_IDLE;
      end
      vncps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        mem_ra   = AW'(in_item.read_cell);
        if (in_valid) begin
          case (in_item.action)
            vncps_pkg::ACT_INSERT: begin
              div_ctrl.start = 1'b1;
              state_next     = vncps_pkg::S_DIV;
            end
            vncps_pkg::ACT_READ: begin
              mem_re     = 1'b1;
              state_next = vncps_pkg::S_READ;
            end
            vncps_pkg::ACT_CLEAR: state_next = vncps_pkg::S_CLEAR;
            default: ;
          endcase
        end
      end
      vncps_pkg::S_READ: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (rd_ok && mq_occ) begin
            out_next = '{cell_occupied: 1'b1, out_x: mq_x, out_y: mq_y, out_z: mq_z,
                         out_payload: mq_pay, out_cell: rd_cell};
          end else begin
            out_next = '{cell_occupied: 1'b0, out_x: '0, out_y: '0, out_z: '0,
                         out_payload: '0, out_cell: rd_cell};
          end
          state_next = vncps_pkg::S_IDLE;
        end
      end
      vncps_pkg::S_DIV: begin
        div_ctrl.step = 1'b1;
        if (div_cnt == 5'd31) state_next = vncps_pkg::S_CELL1;
      end
      vncps_pkg::S_CELL1: state_next = vncps_pkg::S_CELL2;
      vncps_pkg::S_CELL2: state_next = vncps_pkg::S_CELL3;
      vncps_pkg::S_CELL3: state_next = vncps_pkg::S_SQ;
      vncps_pkg::S_SQ:    state_next = vncps_pkg::S_SUM;
      vncps_pkg::S_SUM: begin
        if (in_range) begin
          mem_re     = 1'b1;
          state_next = vncps_pkg::S_CMP;
        end else begin
          state_next = vncps_pkg::S_SPILL;
        end
      end
      vncps_pkg::S_CMP: begin
        // Empty cell takes the point silently; otherwise the loser spills.
        if (!mq_occ) begin
          mem_we     = 1'b1;
          state_next = vncps_pkg::S_IDLE;
        end else if (slot_free) begin
          out_load = 1'b1;
          if (pt_dist < mq_dist) begin
            mem_we   = 1'b1;
            out_next = '{cell_occupied: 1'b1, out_x: mq_x, out_y: mq_y, out_z: mq_z,
                         out_payload: mq_pay, out_cell: cell_full[11:0]};
          end
          state_next = vncps_pkg::S_IDLE;
        end
      end
      vncps_pkg::S_SPILL: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = vncps_pkg::S_IDLE;
        end
      end
      default: state_next = vncps_pkg::S_IDLE;
    endcase
  end

endmodule

/* tb/testbench.sv */
// Testbench for the voxel nearest-center point selector.
// Drives insert, read and clear transactions and checks every result against a predictor.
// Depends on vncps_pkg and the voxel_nearest_center_point_selector_unit RTL.
module testbench;

  localparam int NUM_CELLS = 4096;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  vncps_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vncps_pkg::out_item_t out_item;

  voxel_nearest_center_point_selector_unit DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // Clock generation.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state and the grid settings it mirrors.
  logic signed [31:0] grid_base [3];
  logic [30:0] grid_len;
  logic [12:0] grid_count [3];
  bit cell_full [NUM_CELLS];
  logic [63:0] cell_dist [NUM_CELLS];
  vncps_pkg::out_item_t cell_point [NUM_CELLS];

  vncps_pkg::out_item_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  bit stall_long = 1'b0;
  bit quiet_out = 1'b0;

  // One line per mismatch.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Queues one expected result behind the others.
  task automatic expect_result(input vncps_pkg::out_item_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Cell index along one axis: truncated division, clamped to the cell count.
  function automatic logic [63:0] axis_cell(input logic signed [31:0] p,
      input logic signed [31:0] b, input logic [63:0] len, input logic [12:0] cnt);
    logic signed [63:0] d;
    logic [63:0] q;
    logic [63:0] c;
    c = (cnt == 0) ? 64'd1 : 64'(cnt);
    d = 64'(p) - 64'(b);
    if (d < 0) return 0;
    q = 64'(d) / len;
    return (q >= c) ? c - 1 : q;
  endfunction

  // Squared doubled offset from the cell center along one axis, saturating.
  function automatic logic [63:0] axis_err2(input logic signed [31:0] p,
      input logic signed [31:0] b, input logic [63:0] len, input logic [63:0] idx);
    logic signed [63:0] e;
    logic [63:0] a;
    e = 2 * (64'(p) - 64'(b) - $signed(idx) * $signed(len)) - $signed(len);
    a = (e < 0) ? 64'(-e) : 64'(e);
    if (a > 64'hFFFF_FFFF) return SAT64;
    return a * a;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    return (a > SAT64 - b) ? SAT64 : a + b;
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      vncps_pkg::CFG_BASE_X: grid_base[0] = val;
      vncps_pkg::CFG_BASE_Y: grid_base[1] = val;
      vncps_pkg::CFG_BASE_Z: grid_base[2] = val;
      vncps_pkg::CFG_CELL_LENGTH: grid_len = val[30:0];
      vncps_pkg::CFG_CELLS_X: grid_count[0] = val[12:0];
      vncps_pkg::CFG_CELLS_Y: grid_count[1] = val[12:0];
      vncps_pkg::CFG_CELLS_Z: grid_count[2] = val[12:0];
      default: ;
    endcase
  endtask

  // Works out the result, if any, of one accepted transaction and updates the grid.
  task automatic predict_selection(input vncps_pkg::in_item_t it);
    vncps_pkg::out_item_t r;
    logic [63:0] len, ix, iy, iz, cell_idx, pt_dist, cx, cy;
    r = '0;
    if (it.action == vncps_pkg::ACT_READ) begin
      r.out_cell = it.read_cell;
      if (cell_full[it.read_cell]) begin
        r = cell_point[it.read_cell];
        r.cell_occupied = 1'b1;
        r.out_cell = it.read_cell;
      end
      expect_result(r);
    end else if (it.action == vncps_pkg::ACT_CLEAR) begin
      foreach (cell_full[i]) cell_full[i] = 1'b0;
    end else if (it.action == vncps_pkg::ACT_INSERT) begin
      len = (grid_len == 0) ? 64'd1 : 64'(grid_len);
      cx = (grid_count[0] == 0) ? 64'd1 : 64'(grid_count[0]);
      cy = (grid_count[1] == 0) ? 64'd1 : 64'(grid_count[1]);
      ix = axis_cell(it.point_x, grid_base[0], len, grid_count[0]);
      iy = axis_cell(it.point_y, grid_base[1], len, grid_count[1]);
      iz = axis_cell(it.point_z, grid_base[2], len, grid_count[2]);
      cell_idx = (iz * cy + iy) * cx + ix;
      r.cell_occupied = 1'b1;
      r.out_x = it.point_x;
      r.out_y = it.point_y;
      r.out_z = it.point_z;
      r.out_payload = it.point_payload;
      r.out_cell = cell_idx[11:0];
      if (cell_idx >= NUM_CELLS) begin
        expect_result(r);
        return;
      end
      pt_dist = add_sat(add_sat(axis_err2(it.point_x, grid_base[0], len, ix),
                                axis_err2(it.point_y, grid_base[1], len, iy)),
                        axis_err2(it.point_z, grid_base[2], len, iz));
      if (!cell_full[cell_idx]) begin
        cell_full[cell_idx] = 1'b1;
        cell_dist[cell_idx] = pt_dist;
        cell_point[cell_idx] = r;
      end else if (pt_dist < cell_dist[cell_idx]) begin
        expect_result(cell_point[cell_idx]);
        cell_dist[cell_idx] = pt_dist;
        cell_point[cell_idx] = r;
      end else begin
        expect_result(r);
      end
    end
  endtask

  // Configuration write while the block is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    set_reg(idx, val);
  endtask

  // Offers one transaction after the given gap and returns at the accepting edge.
  // Valid stays high afterwards so that a following item can go out back to back.
  task automatic send_item(input vncps_pkg::in_item_t it, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_selection(it);
  endtask

  // Drops valid, then waits until every result has come and the block is idle again.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0 || !in_ready) @(negedge clk);
  endtask

  function automatic vncps_pkg::in_item_t make_insert(input logic [31:0] x,
      input logic [31:0] y, input logic [31:0] z, input logic [31:0] pay);
    vncps_pkg::in_item_t it;
    it = '0;
    it.action = vncps_pkg::ACT_INSERT;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.point_payload = pay;
    it.read_cell = 12'($urandom());
    return it;
  endfunction

  function automatic vncps_pkg::in_item_t make_action(input logic [1:0] act,
      input logic [11:0] c);
    vncps_pkg::in_item_t it;
    it = '0;
    it.action = act;
    it.point_x = $urandom();
    it.point_y = $urandom();
    it.point_z = $urandom();
    it.point_payload = $urandom();
    it.read_cell = c;
    return it;
  endfunction

  // Random coordinate along one axis, mostly in or near the current grid.
  function automatic logic [31:0] near_coord(input int a);
    logic signed [63:0] span;
    span = 64'(grid_len) * (64'(grid_count[a]) + 1);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'(64'(grid_base[a]) - 64'(grid_len) / 2 + 64'($urandom()) % (span + 1));
  endfunction

  // Output side: random stalls, checking against the oldest expectation.
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_long || quiet_out) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 13) < 4) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk) begin
    vncps_pkg::out_item_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[voxel_nearest_center_point_selector_unit] ERROR");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_item.out_cell), 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_item.cell_occupied !== w.cell_occupied)
          report_mismatch("cell_occupied", 64'(out_item.cell_occupied),
                          64'(w.cell_occupied));
        if (out_item.out_x !== w.out_x)
          report_mismatch("out_x", 64'(out_item.out_x), 64'(w.out_x));
        if (out_item.out_y !== w.out_y)
          report_mismatch("out_y", 64'(out_item.out_y), 64'(w.out_y));
        if (out_item.out_z !== w.out_z)
          report_mismatch("out_z", 64'(out_item.out_z), 64'(w.out_z));
        if (out_item.out_payload !== w.out_payload)
          report_mismatch("out_payload", 64'(out_item.out_payload), 64'(w.out_payload));
        if (out_item.out_cell !== w.out_cell)
          report_mismatch("out_cell", 64'(out_item.out_cell), 64'(w.out_cell));
      end
    end
  end

  // Directed table: an expected result is typed in where it is obvious.
  typedef struct {
    vncps_pkg::in_item_t stim;
    bit has_typed;
    vncps_pkg::out_item_t typed;
  } table_row_t;

  table_row_t directed [$];

  task automatic add_row(input vncps_pkg::in_item_t it, input bit has_t,
                         input vncps_pkg::out_item_t t);
    table_row_t row;
    row.stim = it;
    row.has_typed = has_t;
    row.typed = t;
    directed.insert(directed.size(), row);
  endtask

  function automatic vncps_pkg::out_item_t empty_read(input logic [11:0] c);
    vncps_pkg::out_item_t r;
    r = '0;
    r.out_cell = c;
    return r;
  endfunction

  initial begin
    vncps_pkg::out_item_t none;
    int len_pick;
    none = '0;
    set_reg(vncps_pkg::CFG_BASE_X, 0);
    set_reg(vncps_pkg::CFG_BASE_Y, 0);
    set_reg(vncps_pkg::CFG_BASE_Z, 0);
    set_reg(vncps_pkg::CFG_CELL_LENGTH, 65536);
    set_reg(vncps_pkg::CFG_CELLS_X, 16);
    set_reg(vncps_pkg::CFG_CELLS_Y, 16);
    set_reg(vncps_pkg::CFG_CELLS_Z, 16);
    foreach (cell_full[i]) cell_full[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under reset settings: reads after reset, extremes, all actions.
    add_row(make_action(vncps_pkg::ACT_READ, 12'd0), 1'b1, empty_read(12'd0));
    add_row(make_action(vncps_pkg::ACT_READ, 12'hFFF), 1'b1, empty_read(12'hFFF));
    add_row(make_insert(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'hA5A5_A5A5), 0, none);
    add_row(make_insert(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h5A5A_5A5A), 0, none);
    add_row(make_insert(32'h0000_8001, 32'h0000_7FFF, 32'h0000_8000, 32'hFFFF_FFFF), 0, none);
    add_row(make_action(vncps_pkg::ACT_READ, 12'd0), 0, none);
    add_row(make_insert(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0), 0, none);
    add_row(make_insert(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678), 0, none);
    add_row(make_insert(32'hFFFF_FFFF, 32'h0010_0000, 32'h7FFF_FFFF, 32'h8765_4321), 0, none);
    add_row(make_insert(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 0, none);
    add_row(make_action(vncps_pkg::ACT_READ, 12'hFFF), 0, none);
    add_row(make_action(vncps_pkg::ACT_IGNORED, 12'd5), 1'b0, none);
    add_row(make_action(vncps_pkg::ACT_CLEAR, 12'd0), 1'b0, none);
    add_row(make_action(vncps_pkg::ACT_READ, 12'd0), 1'b1, empty_read(12'd0));
    add_row(make_action(vncps_pkg::ACT_READ, 12'hFFF), 1'b1, empty_read(12'hFFF));
    foreach (directed[i]) begin
      send_item(directed[i].stim, $urandom_range(0, 13));
      if (directed[i].has_typed) begin
        // The typed row must agree with what the predictor just queued.
        if (pending_results[$] !== directed[i].typed)
          report_mismatch("directed row", 64'(pending_results[$]), 64'(directed[i].typed));
      end
    end
    drain();

    // Zero length and zero counts, then a base at the extremes: out-of-range cells spill.
    write_reg(vncps_pkg::CFG_CELL_LENGTH, 0);
    write_reg(vncps_pkg::CFG_CELLS_X, 0);
    write_reg(vncps_pkg::CFG_CELLS_Y, 0);
    write_reg(vncps_pkg::CFG_CELLS_Z, 0);
    write_reg(vncps_pkg::CFG_BASE_X, 32'h8000_0000);
    write_reg(vncps_pkg::CFG_BASE_Y, 32'h7FFF_FFFF);
    write_reg(vncps_pkg::CFG_BASE_Z, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++)
      send_item(make_insert($urandom(), $urandom(), $urandom(), $urandom()), 0);
    send_item(make_action(vncps_pkg::ACT_READ, 12'd0), 0);
    drain();
    write_reg(vncps_pkg::CFG_CELL_LENGTH, 32'h7FFF_FFFF);
    write_reg(vncps_pkg::CFG_CELLS_X, 4096);
    write_reg(vncps_pkg::CFG_CELLS_Y, 4096);
    write_reg(vncps_pkg::CFG_CELLS_Z, 4096);
    for (int i = 0; i < 6; i++)
      send_item(make_insert($urandom(), $urandom(), $urandom(), $urandom()), 0);
    drain();

    // Random phases, each with its own grid; most points land inside the grid.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(vncps_pkg::CFG_BASE_X, (ph == 5) ? 32'h8000_0000 : $urandom());
      write_reg(vncps_pkg::CFG_BASE_Y, $urandom());
      write_reg(vncps_pkg::CFG_BASE_Z, (ph == 4) ? 32'h7FFF_FFFF : $urandom());
      len_pick = $urandom_range(0, 3);
      write_reg(vncps_pkg::CFG_CELL_LENGTH, (len_pick == 0) ? 32'd1 :
                (len_pick == 1) ? 32'h7FFF_FFFF : $urandom_range(2, 1 << 20));
      write_reg(vncps_pkg::CFG_CELLS_X, $urandom_range(1, 8));
      write_reg(vncps_pkg::CFG_CELLS_Y, $urandom_range(1, 8));
      write_reg(vncps_pkg::CFG_CELLS_Z, (ph == 3) ? 4096 : $urandom_range(1, 40));
      for (int k = 0; k < 110; k++) begin
        int pick;
        vncps_pkg::in_item_t it;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          it = make_insert(near_coord(0), near_coord(1), near_coord(2), $urandom());
        end else if (pick < 95) begin
          it = make_action(vncps_pkg::ACT_READ, ($urandom_range(0, 3) == 0) ?
                           12'($urandom()) : 12'($urandom_range(0, 80)));
        end else if (pick < 98) begin
          it = make_action(vncps_pkg::ACT_IGNORED, 12'($urandom()));
        end else begin
          it = make_action(vncps_pkg::ACT_CLEAR, 12'($urandom()));
        end
        // A long receiver hold-off while items keep coming.
        if (ph == 1 && k == 20) begin
          fork
            begin
              stall_long = 1'b1;
              repeat (600) @(posedge clk);
              stall_long = 1'b0;
            end
          join_none
        end
        // A sender pause until every result has come.
        if (ph == 2 && k == 50) drain();
        // Stretches with no idling at all.
        send_item(it, (k % 30 < 8) ? 0 : $urandom_range(0, 13));
      end
      drain();
      wait (!stall_long);
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[voxel_nearest_center_point_selector_unit] OK");
    end else begin
      $display("[voxel_nearest_center_point_selector_unit] ERROR");
    end
    $finish;
  end
endmodule
